// ===== src/upd_pkg.sv =====
// upd_pkg: types, character constants and the hex digit decoder shared by
// the url percent decoder modules. no dependencies.
`timescale 1ns / 1ps

package upd_pkg;

   localparam logic [15:0] CH_PERCENT   = 16'h0025;
   localparam logic [15:0] CH_QUESTION  = 16'h003F;
   localparam logic [15:0] CH_SLASH     = 16'h002F;
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;

   localparam logic [1:0] PEND_NONE   = 2'd0;
   localparam logic [1:0] PEND_ONE    = 2'd1;
   localparam logic [1:0] PEND_TWO    = 2'd2;
   localparam logic [1:0] PEND_UNUSED = 2'd3;

   localparam int MAX_CHARS   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] in_char;
      logic        in_last;
   } req_item_type;

   typedef struct packed {
      logic [15:0] out_char;
      logic        out_last;
   } rsp_item_type;

   // output characters caused by one input beat
   typedef struct packed {
      logic [MAX_CHARS-1:0][15:0] chars;
      logic [1:0]                 count;
      logic                       last;
   } group_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [1:0] pending_count;
      logic       query_seen;
   } front_status_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic hex_type hex_decode(input logic [15:0] c);
      hex_type h;
      h.is_hex = 1'b0;
      h.value  = 4'd0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         h.is_hex = 1'b1;
         h.value  = c[3:0];
      end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
         h.is_hex = 1'b1;
         h.value  = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

// ===== src/url_percent_decoder_core.sv =====
// url_percent_decoder_core: top level, front classifier, group queue and
// output serialiser. uses upd_pkg, upd_front, upd_queue, upd_back.
// path: characters of a taken beat pass the group queue, then the result register.
// throughput: one input beat per cycle while req_full is low; the characters of
// a beat leave one at a time, the four-entry group queue absorbs short bursts.
// reset: synchronous, clears held characters, query flag, queue and output valid.
`timescale 1ns / 1ps

module url_percent_decoder_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  upd_pkg::req_item_type req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output upd_pkg::rsp_item_type rsp_data
);

   logic                        accept;
   logic                        grp_push;
   upd_pkg::group_type          grp;
   upd_pkg::group_type          head;
   logic                        head_pop;
   upd_pkg::front_status_type   front_status;
   upd_pkg::queue_status_type   queue_status;

   assign req_full = queue_status.full;
   assign accept   = req_push && !req_full;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item       (req_data),
      .grp_push   (grp_push),
      .grp        (grp),
      .status     (front_status)
   );

   upd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp),
      .pop       (head_pop),
      .head      (head),
      .status    (queue_status)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (queue_status.empty),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.in_last |=>
         front_status.pending_count == upd_pkg::PEND_NONE && !front_status.query_seen)
      else $error("state not cleared after last beat");

   a_no_bad_pending: assert property (@(posedge clock) disable iff (reset)
      front_status.pending_count != upd_pkg::PEND_UNUSED)
      else $error("invalid pending count");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue both full and empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("outputs not idle after reset");

endmodule

// ===== src/upd_front.sv =====
// upd_front: classifies each input beat, tracks held escape characters and
// the query flag, and builds the group of output characters. uses upd_pkg.
`timescale 1ns / 1ps

module upd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  upd_pkg::req_item_type       item,
   output logic                        grp_push,
   output upd_pkg::group_type          grp,
   output upd_pkg::front_status_type   status
);

   logic [1:0]  count_ff, count_in;
   logic [15:0] digit_ff, digit_in;
   logic        query_ff, query_in;

   always_comb begin
      upd_pkg::hex_type                    cur;
      upd_pkg::hex_type                    hi;
      logic [1:0]                          n;
      logic [upd_pkg::MAX_CHARS-1:0][15:0] b;
      logic                                taken;
      logic [15:0]                         dec;

      cur      = upd_pkg::hex_decode(item.in_char);
      hi       = upd_pkg::hex_decode(digit_ff);
      dec      = {8'h00, hi.value, cur.value};
      count_in = count_ff;
      digit_in = digit_ff;
      query_in = query_ff;
      n        = 2'd0;
      b        = '0;
      taken    = 1'b0;

      unique case (count_ff)
         upd_pkg::PEND_TWO: begin
            count_in = upd_pkg::PEND_NONE;
            if (cur.is_hex) begin
               b[0]  = dec;
               n     = 2'd1;
               taken = 1'b1;
               if (dec == upd_pkg::CH_QUESTION) query_in = 1'b1;
            end else begin
               b[0] = upd_pkg::CH_PERCENT;
               b[1] = digit_ff;
               n    = 2'd2;
            end
         end
         upd_pkg::PEND_ONE: begin
            if (cur.is_hex) begin
               digit_in = item.in_char;
               count_in = upd_pkg::PEND_TWO;
               taken    = 1'b1;
            end else begin
               count_in = upd_pkg::PEND_NONE;
               b[0]     = upd_pkg::CH_PERCENT;
               n        = 2'd1;
            end
         end
         default: begin
            count_in = upd_pkg::PEND_NONE;
         end
      endcase

      if (!taken) begin
         if (item.in_char == upd_pkg::CH_PERCENT) begin
            count_in = upd_pkg::PEND_ONE;
         end else if (item.in_char == upd_pkg::CH_SLASH && query_ff) begin
            b[n] = upd_pkg::CH_BACKSLASH;
            n    = n + 2'd1;
         end else begin
            b[n] = item.in_char;
            n    = n + 2'd1;
         end
      end

      // end of url: flush held characters
      if (item.in_last) begin
         if ((count_in == upd_pkg::PEND_ONE || count_in == upd_pkg::PEND_TWO)
             && n < 2'd3) begin
            b[n] = upd_pkg::CH_PERCENT;
            n    = n + 2'd1;
         end
         if (count_in == upd_pkg::PEND_TWO && n < 2'd3) begin
            b[n] = digit_in;
            n    = n + 2'd1;
         end
         count_in = upd_pkg::PEND_NONE;
         digit_in = 16'h0000;
         query_in = 1'b0;
      end

      grp.chars = b;
      grp.count = n;
      grp.last  = item.in_last;
      grp_push  = item_valid && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= upd_pkg::PEND_NONE;
         digit_ff <= 16'h0000;
         query_ff <= 1'b0;
      end else if (item_valid) begin
         count_ff <= count_in;
         digit_ff <= digit_in;
         query_ff <= query_in;
      end
   end

   assign status.pending_count = count_ff;
   assign status.query_seen    = query_ff;

endmodule

// ===== src/upd_queue.sv =====
// upd_queue: short register queue of character groups between front and
// back. uses upd_pkg.
`timescale 1ns / 1ps

module upd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  upd_pkg::group_type         push_data,
   input  logic                       pop,
   output upd_pkg::group_type         head,
   output upd_pkg::queue_status_type  status
);

   upd_pkg::group_type                mem_ff [upd_pkg::QUEUE_DEPTH];
   logic [upd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [upd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [upd_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push, do_pop;

   localparam logic [upd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      upd_pkg::QUEUE_PTR_W'(upd_pkg::QUEUE_DEPTH - 1);
   localparam logic [upd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      upd_pkg::QUEUE_CNT_W'(upd_pkg::QUEUE_DEPTH);

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== src/upd_back.sv =====
// upd_back: walks the head group one character per beat into the result
// register, holding while an unpopped result is waiting. uses upd_pkg.
`timescale 1ns / 1ps

module upd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  upd_pkg::group_type    head,
   input  logic                  head_empty,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output upd_pkg::rsp_item_type rsp_data
);

   logic [1:0]            idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   upd_pkg::rsp_item_type data_ff, data_in;
   logic                  load, at_end;

   assign load     = !head_empty && (!valid_ff || rsp_pop);
   assign at_end   = (idx_ff == head.count - 2'd1);
   assign head_pop = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in         = 1'b1;
         data_in.out_char = head.chars[idx_ff];
         data_in.out_last = head.last && at_end;
         idx_in           = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

endmodule
